// File: design/lvqps_pkg.sv
`default_nettype none
package lvqps_pkg;

    localparam int NUM_NEURONS_DEF = 1024;
    localparam int MAX_DIMS_DEF    = 64;

    localparam int REQ_W   = 3;
    localparam int NIDX_W  = 10;
    localparam int DIDX_W  = 6;
    localparam int VAL_W   = 16;
    localparam int RANGE_W = 11;
    localparam int DIST_W  = 38;
    localparam int LR_W    = 16;
    localparam int DIMS_W  = 7;
    localparam int PROD_W  = 32;
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 32;

    localparam logic [DIMS_W-1:0] DIMS_RESET = 7'd64;
    localparam logic [LR_W-1:0]   LR_RESET   = 16'd0;

    // register index, taken from paddr[2]
    localparam logic REG_LR   = 1'b0;
    localparam logic REG_DIMS = 1'b1;

    typedef enum logic [REQ_W-1:0] {
        REQ_WR_WEIGHT = 3'd0,
        REQ_WR_SAMPLE = 3'd1,
        REQ_SEARCH    = 3'd2,
        REQ_UPDATE    = 3'd3,
        REQ_RD_WEIGHT = 3'd4
    } t_req;

    // tag that travels with one weight element through the datapath
    typedef struct packed {
        logic               valid;
        logic               upd;
        logic               first;
        logic               last;
        logic [RANGE_W-1:0] neuron;
    } t_tag;

endpackage
`default_nettype wire

// File: design/lvqps_ram.sv
`default_nettype none
module lvqps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// File: design/lvqps_cfg.sv
`default_nettype none
module lvqps_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lvqps_pkg::CFG_AW-1:0]  paddr,
    input  wire logic [lvqps_pkg::CFG_DW-1:0]  pwdata,
    output logic      [lvqps_pkg::CFG_DW-1:0]  prdata,
    output logic                               pready,
    output logic      [lvqps_pkg::LR_W-1:0]    o_learning_rate,
    output logic      [lvqps_pkg::DIMS_W-1:0]  o_dims_used
);

    logic [lvqps_pkg::LR_W-1:0]   r_lr;
    logic [lvqps_pkg::DIMS_W-1:0] r_dims;
    logic                         w_wr;
    logic                         w_idx;

    assign w_wr  = psel & penable & pwrite;
    // low address bits are don't care
    assign w_idx = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr   <= lvqps_pkg::LR_RESET;
            r_dims <= lvqps_pkg::DIMS_RESET;
        end else if (w_wr) begin
            case (w_idx)
                lvqps_pkg::REG_LR:   r_lr   <= pwdata[lvqps_pkg::LR_W-1:0];
                lvqps_pkg::REG_DIMS: r_dims <= pwdata[lvqps_pkg::DIMS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            lvqps_pkg::REG_LR:   prdata = lvqps_pkg::CFG_DW'(r_lr);
            lvqps_pkg::REG_DIMS: prdata = lvqps_pkg::CFG_DW'(r_dims);
            default:             prdata = '0;
        endcase
    end

    assign pready          = 1'b1;
    assign o_learning_rate = r_lr;
    assign o_dims_used     = r_dims;

endmodule
`default_nettype wire

// File: design/lvqps_calc.sv
`default_nettype none
module lvqps_calc #(
    parameter int AW = 16,
    parameter int DW = 38
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire lvqps_pkg::t_tag               i_tag,
    input  wire logic [AW-1:0]                 i_addr,
    input  wire logic [lvqps_pkg::VAL_W-1:0]   i_weight,
    input  wire logic [lvqps_pkg::VAL_W-1:0]   i_sample,
    input  wire logic [lvqps_pkg::LR_W-1:0]    i_alpha,
    input  wire logic                          i_repel,
    output logic                               o_busy,
    output logic                               o_we,
    output logic      [AW-1:0]                 o_waddr,
    output logic      [lvqps_pkg::VAL_W-1:0]   o_wdata,
    output logic      [lvqps_pkg::RANGE_W-1:0] o_best_n,
    output logic      [DW-1:0]                 o_best_dist
);

    localparam int VW = lvqps_pkg::VAL_W;
    localparam int PW = lvqps_pkg::PROD_W;

    // stage 2: |x - w| times itself (search) or times alpha (update)
    logic [VW-1:0]   w_absdiff;
    logic [VW-1:0]   w_mult;
    lvqps_pkg::t_tag r_s2_tag;
    logic [PW-1:0]   r_s2_prod;
    logic [VW-1:0]   r_s2_w;
    logic            r_s2_toward;
    logic [AW-1:0]   r_s2_addr;

    // stage 3: accumulate or write back
    logic [VW-1:0]   w_step;
    logic [VW:0]     w_up;
    logic [VW-1:0]   w_new;
    lvqps_pkg::t_tag w_s3_tag;
    lvqps_pkg::t_tag r_s3_tag;
    logic [DW-1:0]   r_acc;

    // stage 4: running minimum
    logic                          r_have;
    logic [lvqps_pkg::RANGE_W-1:0] r_best_n;
    logic [DW-1:0]                 r_best_dist;
    logic                          w_take;

    assign w_absdiff = (i_sample >= i_weight) ? (i_sample - i_weight) : (i_weight - i_sample);
    assign w_mult    = i_tag.upd ? i_alpha : w_absdiff;

    assign w_step = r_s2_prod[PW-1:VW];
    assign w_up   = {1'b0, r_s2_w} + {1'b0, w_step};

    always_comb begin
        if (r_s2_toward) begin
            w_new = w_up[VW] ? '1 : w_up[VW-1:0];
        end else begin
            w_new = (w_step > r_s2_w) ? '0 : (r_s2_w - w_step);
        end
    end

    // only search elements go on to the compare stage
    always_comb begin
        w_s3_tag       = r_s2_tag;
        w_s3_tag.valid = r_s2_tag.valid & ~r_s2_tag.upd;
    end

    assign o_we    = r_s2_tag.valid & r_s2_tag.upd;
    assign o_waddr = r_s2_addr;
    assign o_wdata = w_new;

    // strict compare keeps the first minimum
    assign w_take = r_s3_tag.valid & r_s3_tag.last & (~r_have | (r_acc < r_best_dist));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_tag <= '0;
            r_s3_tag <= '0;
            r_have   <= 1'b0;
        end else begin
            r_s2_tag <= i_tag;
            r_s3_tag <= w_s3_tag;
            if (i_start) begin
                r_have <= 1'b0;
            end else if (w_take) begin
                r_have <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_prod   <= PW'(w_absdiff) * PW'(w_mult);
        r_s2_w      <= i_weight;
        r_s2_toward <= (i_sample >= i_weight) ^ i_repel;
        r_s2_addr   <= i_addr;
        if (r_s2_tag.valid && !r_s2_tag.upd) begin
            r_acc <= (r_s2_tag.first ? '0 : r_acc) + DW'(r_s2_prod);
        end
        if (w_take) begin
            r_best_n    <= r_s3_tag.neuron;
            r_best_dist <= r_acc;
        end
    end

    assign o_busy      = i_tag.valid | r_s2_tag.valid | r_s3_tag.valid;
    assign o_best_n    = r_best_n;
    assign o_best_dist = r_best_dist;

endmodule
`default_nettype wire

// File: design/lvq_prototype_search_update.sv
`default_nettype none
// LVQ prototype store with best-matching-unit search and LVQ1 update.
// Input channel i_valid/o_ready carries one request per transfer: weight write,
// sample write, weight read, search over [range_low, range_high) or update of
// one prototype. Output channel o_valid/i_ready returns exactly one result per
// request; fields not produced by the request are zero.
// One request is processed at a time. Searches and updates are paced by the
// single read port of the weight memory, which delivers one weight element per
// cycle into a 3-stage multiply/accumulate/compare pipeline.
// Updates write back through the same pipeline; it drains before the result.
// The output register decouples the sides: a new request is taken while the
// previous result still waits; its own result then holds until the receiver
// takes the first one.
// Reset: learning_rate 0, dims_used 64, no result pending. Weight and sample
// memories are not cleared and hold unknown data until written.
// Configuration sits on the APB port: learning_rate at 0x0, dims_used at 0x4.
module lvq_prototype_search_update #(
    parameter int NUM_NEURONS = lvqps_pkg::NUM_NEURONS_DEF,
    parameter int MAX_DIMS    = lvqps_pkg::MAX_DIMS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [lvqps_pkg::REQ_W-1:0]   i_req_type,
    input  wire logic [lvqps_pkg::NIDX_W-1:0]  i_neuron_index,
    input  wire logic [lvqps_pkg::DIDX_W-1:0]  i_dim_index,
    input  wire logic [lvqps_pkg::VAL_W-1:0]   i_value,
    input  wire logic [lvqps_pkg::RANGE_W-1:0] i_range_low,
    input  wire logic [lvqps_pkg::RANGE_W-1:0] i_range_high,
    input  wire logic                          i_update_sign,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic      [lvqps_pkg::NIDX_W-1:0]  o_winner_index,
    output logic      [lvqps_pkg::DIST_W-1:0]  o_winner_distance,
    output logic      [lvqps_pkg::VAL_W-1:0]   o_read_value,
    output logic                               o_empty_range,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lvqps_pkg::CFG_AW-1:0]  paddr,
    input  wire logic [lvqps_pkg::CFG_DW-1:0]  pwdata,
    output logic      [lvqps_pkg::CFG_DW-1:0]  prdata,
    output logic                               pready
);

    localparam int AW  = $clog2(NUM_NEURONS * MAX_DIMS);
    localparam int SAW = $clog2(MAX_DIMS);
    localparam int DW  = (32 + $clog2(MAX_DIMS) > lvqps_pkg::DIST_W) ?
                         (32 + $clog2(MAX_DIMS)) : lvqps_pkg::DIST_W;
    localparam int RW  = lvqps_pkg::RANGE_W;
    localparam int DMW = lvqps_pkg::DIMS_W;
    localparam int VW  = lvqps_pkg::VAL_W;
    localparam int NW  = lvqps_pkg::NIDX_W;
    localparam int SW  = lvqps_pkg::DIST_W;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_DRAIN  = 5'b00100,
        S_RDWAIT = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    function automatic logic [AW-1:0] f_addr(input logic [RW-1:0] n, input logic [DMW-1:0] d);
        return AW'(n) * AW'(MAX_DIMS) + AW'(d);
    endfunction

    // configuration
    logic [lvqps_pkg::LR_W-1:0] w_lr;
    logic [DMW-1:0]             w_dims;

    // control
    t_state          r_state, n_state;
    lvqps_pkg::t_tag r_p1_tag, n_p1_tag;
    logic            r_ov, n_ov;

    // scan and result payload
    logic [RW-1:0]  r_n, n_n;
    logic [RW-1:0]  r_hi, n_hi;
    logic [DMW-1:0] r_d, n_d;
    logic [DMW-1:0] r_last_d, n_last_d;
    logic           r_upd, n_upd;
    logic           r_repel, n_repel;
    logic           r_rd_ok, n_rd_ok;
    logic [AW-1:0]  r_p1_addr, n_p1_addr;
    logic [NW-1:0]  r_win, n_win;
    logic [SW-1:0]  r_dist, n_dist;
    logic [VW-1:0]  r_rd, n_rd;
    logic           r_empty, n_empty;
    logic [NW-1:0]  r_o_win, n_o_win;
    logic [SW-1:0]  r_o_dist, n_o_dist;
    logic [VW-1:0]  r_o_rd, n_o_rd;
    logic           r_o_empty, n_o_empty;

    // combinational helpers
    logic           w_acc;
    logic           w_nvalid;
    logic           w_dvalid;
    logic [DMW-1:0] w_eff;
    logic [RW-1:0]  w_hic;
    logic [AW-1:0]  w_in_addr;
    logic [AW-1:0]  w_scan_addr;
    logic [RW-1:0]  w_n_inc;
    logic           w_start;

    // memories
    logic           w_w_we;
    logic [AW-1:0]  w_w_waddr;
    logic [VW-1:0]  w_w_wdata;
    logic [AW-1:0]  w_w_raddr;
    logic [VW-1:0]  w_w_q;
    logic           w_s_we;
    logic [VW-1:0]  w_s_q;

    // datapath
    logic           w_busy;
    logic           w_upd_we;
    logic [AW-1:0]  w_upd_waddr;
    logic [VW-1:0]  w_upd_wdata;
    logic [RW-1:0]  w_best_n;
    logic [DW-1:0]  w_best_dist;

    lvqps_cfg u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_learning_rate (w_lr),
        .o_dims_used     (w_dims)
    );

    assign o_ready  = (r_state == S_IDLE);
    assign w_acc    = i_valid & o_ready;
    assign w_nvalid = (int'(i_neuron_index) < NUM_NEURONS);
    assign w_dvalid = (int'(i_dim_index) < MAX_DIMS);
    assign w_eff    = (int'(w_dims) > MAX_DIMS) ? DMW'(MAX_DIMS) : w_dims;
    assign w_hic    = (int'(i_range_high) > NUM_NEURONS) ? RW'(NUM_NEURONS) : i_range_high;

    assign w_in_addr   = f_addr(RW'(i_neuron_index), DMW'(i_dim_index));
    assign w_scan_addr = f_addr(r_n, r_d);
    assign w_n_inc     = r_n + RW'(1);
    assign w_start     = w_acc & (lvqps_pkg::t_req'(i_req_type) == lvqps_pkg::REQ_SEARCH);

    // weight memory: request writes in idle, update write-back during a scan or drain
    assign w_w_we    = (w_acc && lvqps_pkg::t_req'(i_req_type) == lvqps_pkg::REQ_WR_WEIGHT
                        && w_nvalid && w_dvalid) || w_upd_we;
    assign w_w_waddr = w_upd_we ? w_upd_waddr : w_in_addr;
    assign w_w_wdata = w_upd_we ? w_upd_wdata : i_value;
    assign w_w_raddr = (r_state == S_IDLE) ? w_in_addr : w_scan_addr;

    assign w_s_we = w_acc && lvqps_pkg::t_req'(i_req_type) == lvqps_pkg::REQ_WR_SAMPLE
                    && w_dvalid;

    lvqps_ram #(
        .WIDTH (VW),
        .DEPTH (NUM_NEURONS * MAX_DIMS)
    ) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (w_w_we),
        .i_waddr (w_w_waddr),
        .i_wdata (w_w_wdata),
        .i_raddr (w_w_raddr),
        .o_rdata (w_w_q)
    );

    lvqps_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_DIMS)
    ) u_sample_ram (
        .i_clk   (i_clk),
        .i_we    (w_s_we),
        .i_waddr (SAW'(i_dim_index)),
        .i_wdata (i_value),
        .i_raddr (SAW'(r_d)),
        .o_rdata (w_s_q)
    );

    lvqps_calc #(
        .AW (AW),
        .DW (DW)
    ) u_calc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_tag       (r_p1_tag),
        .i_addr      (r_p1_addr),
        .i_weight    (w_w_q),
        .i_sample    (w_s_q),
        .i_alpha     (w_lr),
        .i_repel     (r_repel),
        .o_busy      (w_busy),
        .o_we        (w_upd_we),
        .o_waddr     (w_upd_waddr),
        .o_wdata     (w_upd_wdata),
        .o_best_n    (w_best_n),
        .o_best_dist (w_best_dist)
    );

    always_comb begin
        n_state   = r_state;
        n_p1_tag  = '0;
        n_ov      = r_ov & ~i_ready;
        n_n       = r_n;
        n_hi      = r_hi;
        n_d       = r_d;
        n_last_d  = r_last_d;
        n_upd     = r_upd;
        n_repel   = r_repel;
        n_rd_ok   = r_rd_ok;
        n_p1_addr = r_p1_addr;
        n_win     = r_win;
        n_dist    = r_dist;
        n_rd      = r_rd;
        n_empty   = r_empty;
        n_o_win   = r_o_win;
        n_o_dist  = r_o_dist;
        n_o_rd    = r_o_rd;
        n_o_empty = r_o_empty;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_win   = '0;
                    n_dist  = '0;
                    n_rd    = '0;
                    n_empty = 1'b0;
                    n_state = S_DONE;
                    case (lvqps_pkg::t_req'(i_req_type))
                        lvqps_pkg::REQ_SEARCH: begin
                            if (i_range_low >= w_hic) begin
                                n_empty = 1'b1;
                            end else if (w_eff <= DMW'(1)) begin
                                // no distance dimensions: every neuron ties at zero
                                n_win = i_range_low[NW-1:0];
                            end else begin
                                n_n      = i_range_low;
                                n_hi     = w_hic;
                                n_d      = '0;
                                n_last_d = w_eff - DMW'(2);
                                n_upd    = 1'b0;
                                n_state  = S_SCAN;
                            end
                        end
                        lvqps_pkg::REQ_UPDATE: begin
                            if (w_nvalid && w_eff != '0) begin
                                n_n      = RW'(i_neuron_index);
                                n_hi     = RW'(i_neuron_index) + RW'(1);
                                n_d      = '0;
                                n_last_d = w_eff - DMW'(1);
                                n_upd    = 1'b1;
                                n_repel  = i_update_sign;
                                n_state  = S_SCAN;
                            end
                        end
                        lvqps_pkg::REQ_RD_WEIGHT: begin
                            n_rd_ok = w_nvalid & w_dvalid;
                            n_state = S_RDWAIT;
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                n_p1_tag.valid  = 1'b1;
                n_p1_tag.upd    = r_upd;
                n_p1_tag.first  = (r_d == '0);
                n_p1_tag.last   = (r_d == r_last_d);
                n_p1_tag.neuron = r_n;
                n_p1_addr       = w_scan_addr;
                if (r_d == r_last_d) begin
                    n_d = '0;
                    n_n = w_n_inc;
                    if (w_n_inc == r_hi) begin
                        n_state = S_DRAIN;
                    end
                end else begin
                    n_d = r_d + DMW'(1);
                end
            end
            S_DRAIN: begin
                if (!w_busy) begin
                    if (!r_upd) begin
                        n_win  = w_best_n[NW-1:0];
                        n_dist = w_best_dist[SW-1:0];
                    end
                    n_state = S_DONE;
                end
            end
            S_RDWAIT: begin
                n_rd    = r_rd_ok ? w_w_q : '0;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ov || i_ready) begin
                    n_ov      = 1'b1;
                    n_o_win   = r_win;
                    n_o_dist  = r_dist;
                    n_o_rd    = r_rd;
                    n_o_empty = r_empty;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_p1_tag <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_p1_tag <= n_p1_tag;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n       <= n_n;
        r_hi      <= n_hi;
        r_d       <= n_d;
        r_last_d  <= n_last_d;
        r_upd     <= n_upd;
        r_repel   <= n_repel;
        r_rd_ok   <= n_rd_ok;
        r_p1_addr <= n_p1_addr;
        r_win     <= n_win;
        r_dist    <= n_dist;
        r_rd      <= n_rd;
        r_empty   <= n_empty;
        r_o_win   <= n_o_win;
        r_o_dist  <= n_o_dist;
        r_o_rd    <= n_o_rd;
        r_o_empty <= n_o_empty;
    end

    assign o_valid           = r_ov;
    assign o_winner_index    = r_o_win;
    assign o_winner_distance = r_o_dist;
    assign o_read_value      = r_o_rd;
    assign o_empty_range     = r_o_empty;

endmodule
`default_nettype wire

// File: verif/lvq_bmu_checker.sv
`default_nettype none
module lvq_bmu_checker #(
    parameter int NUM_NEURONS = lvqps_pkg::NUM_NEURONS_DEF,
    parameter int MAX_DIMS    = lvqps_pkg::MAX_DIMS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic                          i_in_ready,
    input  wire logic [lvqps_pkg::REQ_W-1:0]   i_req_type,
    input  wire logic [lvqps_pkg::NIDX_W-1:0]  i_neuron_index,
    input  wire logic [lvqps_pkg::DIDX_W-1:0]  i_dim_index,
    input  wire logic [lvqps_pkg::VAL_W-1:0]   i_value,
    input  wire logic [lvqps_pkg::RANGE_W-1:0] i_range_low,
    input  wire logic [lvqps_pkg::RANGE_W-1:0] i_range_high,
    input  wire logic                          i_update_sign,
    input  wire logic                          i_out_valid,
    input  wire logic                          i_out_ready,
    input  wire logic [lvqps_pkg::NIDX_W-1:0]  i_winner_index,
    input  wire logic [lvqps_pkg::DIST_W-1:0]  i_winner_distance,
    input  wire logic [lvqps_pkg::VAL_W-1:0]   i_read_value,
    input  wire logic                          i_empty_range,
    input  wire logic                          i_psel,
    input  wire logic                          i_penable,
    input  wire logic                          i_pwrite,
    input  wire logic [lvqps_pkg::CFG_AW-1:0]  i_paddr,
    input  wire logic [lvqps_pkg::CFG_DW-1:0]  i_pwdata,
    input  wire logic                          i_pready,
    output int                                 o_pending,
    output int                                 o_fail_count
);
    import lvqps_pkg::*;

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [NIDX_W-1:0] win;
        logic [DIST_W-1:0] sqd;
        logic [VAL_W-1:0]  rdv;
        logic              is_empty;
    } t_result;

    // model copy of the prototype and sample memories
    bit [VAL_W-1:0]    weights [NUM_NEURONS*MAX_DIMS];
    bit [VAL_W-1:0]    sample  [MAX_DIMS];
    logic [LR_W-1:0]   alpha    = LR_RESET;
    logic [DIMS_W-1:0] dims_cfg = DIMS_RESET;
    t_result           results_due [$];
    int                due_cnt  = 0;
    int                fails    = 0;
    int                reported = 0;

    assign o_pending    = due_cnt;
    assign o_fail_count = fails;

    function automatic int unsigned dims_eff();
        return (dims_cfg > MAX_DIMS) ? MAX_DIMS : 32'(dims_cfg);
    endfunction

    // squared distance over all dimensions but the label one
    function automatic longint unsigned dist_to(input int unsigned n);
        int unsigned       nd;
        int unsigned       d;
        longint            df;
        longint unsigned   acc;
        nd  = dims_eff();
        nd  = (nd > 0) ? nd - 1 : 0;
        acc = 0;
        for (d = 0; d < nd; d++) begin
            df  = longint'(sample[d]) - longint'(weights[n*MAX_DIMS+d]);
            if (df < 0)
                df = -df;
            acc += longint'(df) * longint'(df);
        end
        return acc;
    endfunction

    task automatic adapt(input int unsigned n, input logic repel);
        int unsigned nd;
        int unsigned d;
        longint      w;
        longint      df;
        longint      mag;
        longint      step;
        nd = dims_eff();
        for (d = 0; d < nd; d++) begin
            w    = longint'(weights[n*MAX_DIMS+d]);
            df   = longint'(sample[d]) - w;
            mag  = (df < 0) ? -df : df;
            step = (longint'(alpha) * mag) >> 16;
            if (df < 0)
                step = -step;
            w = repel ? w - step : w + step;
            if (w < 0)
                w = 0;
            if (w > 65535)
                w = 65535;
            weights[n*MAX_DIMS+d] = w[VAL_W-1:0];
        end
    endtask

    task automatic predict_request();
        t_result         r;
        int unsigned     lo;
        int unsigned     hi;
        int unsigned     n;
        int unsigned     best;
        longint unsigned best_d;
        longint unsigned dd;
        r = '0;
        case (i_req_type)
            REQ_WR_WEIGHT: begin
                if (i_neuron_index < NUM_NEURONS && i_dim_index < MAX_DIMS)
                    weights[i_neuron_index*MAX_DIMS+i_dim_index] = i_value;
            end
            REQ_WR_SAMPLE: begin
                if (i_dim_index < MAX_DIMS)
                    sample[i_dim_index] = i_value;
            end
            REQ_SEARCH: begin
                lo = 32'(i_range_low);
                hi = 32'(i_range_high);
                if (hi > NUM_NEURONS)
                    hi = NUM_NEURONS;
                if (lo >= hi) begin
                    r.is_empty = 1'b1;
                end else begin
                    best   = lo;
                    best_d = dist_to(lo);
                    // strict compare keeps the first of equal distances
                    for (n = lo + 1; n < hi; n++) begin
                        dd = dist_to(n);
                        if (dd < best_d) begin
                            best_d = dd;
                            best   = n;
                        end
                    end
                    r.win = best[NIDX_W-1:0];
                    r.sqd = best_d[DIST_W-1:0];
                end
            end
            REQ_UPDATE: begin
                if (i_neuron_index < NUM_NEURONS)
                    adapt(32'(i_neuron_index), i_update_sign);
            end
            REQ_RD_WEIGHT: begin
                if (i_neuron_index < NUM_NEURONS && i_dim_index < MAX_DIMS)
                    r.rdv = weights[i_neuron_index*MAX_DIMS+i_dim_index];
            end
            default: ;
        endcase
        results_due.push_back(r);
    endtask

    task automatic check_result();
        t_result got;
        t_result exp_r;
        got = '{i_winner_index, i_winner_distance, i_read_value, i_empty_range};
        if (results_due.size() == 0) begin
            fails++;
            if (reported < MAX_REPORTS) begin
                reported++;
                $display("check: result with nothing pending: idx=%0d dist=%0d rd=%h empty=%0b",
                         got.win, got.sqd, got.rdv, got.is_empty);
            end
        end else begin
            exp_r = results_due.pop_front();
            if (got !== exp_r) begin
                fails++;
                if (reported < MAX_REPORTS) begin
                    reported++;
                    $display("check: mismatch expected idx=%0d dist=%0d rd=%h empty=%0b",
                             exp_r.win, exp_r.sqd, exp_r.rdv, exp_r.is_empty);
                    $display("check:          actual   idx=%0d dist=%0d rd=%h empty=%0b",
                             got.win, got.sqd, got.rdv, got.is_empty);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            alpha    = LR_RESET;
            dims_cfg = DIMS_RESET;
            results_due.delete();
        end else begin
            // result leaves before a same-edge request can add its own
            if (i_out_valid && i_out_ready)
                check_result();
            if (i_in_valid && i_in_ready)
                predict_request();
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_LR)
                    alpha = i_pwdata[LR_W-1:0];
                else
                    dims_cfg = i_pwdata[DIMS_W-1:0];
            end
        end
        due_cnt = results_due.size();
    end

endmodule
`default_nettype wire

// File: verif/tb_lvq_prototype_search_update.sv
`default_nettype none
module tb_lvq_prototype_search_update;
    import lvqps_pkg::*;

    localparam int N_PRELOAD   = 4;                  // neurons 0..3 fully written
    localparam int TOP_NEURON  = NUM_NEURONS_DEF - 1;
    localparam int N_PHASES    = 8;
    localparam int PHASE_ITEMS = 36;
    localparam int LONG_HOLD   = 400;
    localparam int CYCLE_LIMIT = 2000000;
    localparam logic [REQ_W-1:0] REQ_UNKNOWN_FIRST = 3'd5;
    localparam logic [REQ_W-1:0] REQ_UNKNOWN_LAST  = 3'd7;
    localparam logic [VAL_W-1:0] VAL_MAX = 16'hFFFF;
    localparam logic [VAL_W-1:0] VAL_MID = 16'h8000;

    typedef struct packed {
        logic [REQ_W-1:0]   req;
        logic [NIDX_W-1:0]  nidx;
        logic [DIDX_W-1:0]  didx;
        logic [VAL_W-1:0]   val;
        logic [RANGE_W-1:0] lo;
        logic [RANGE_W-1:0] hi;
        logic               sgn;
    } t_item;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic               in_valid     = 1'b0;
    wire                in_ready;
    logic [REQ_W-1:0]   req_type     = '0;
    logic [NIDX_W-1:0]  neuron_index = '0;
    logic [DIDX_W-1:0]  dim_index    = '0;
    logic [VAL_W-1:0]   value        = '0;
    logic [RANGE_W-1:0] range_low    = '0;
    logic [RANGE_W-1:0] range_high   = '0;
    logic               update_sign  = 1'b0;
    wire                out_valid;
    logic               out_ready    = 1'b0;
    wire [NIDX_W-1:0]   winner_index;
    wire [DIST_W-1:0]   winner_distance;
    wire [VAL_W-1:0]    read_value;
    wire                empty_range;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [CFG_AW-1:0]  paddr   = '0;
    logic [CFG_DW-1:0]  pwdata  = '0;
    wire [CFG_DW-1:0]   prdata;
    wire                pready;

    int pending;
    int fail_count;

    bit tx_idle   = 1'b1;
    bit rx_idle   = 1'b1;
    bit long_hold = 1'b0;

    int cycle_cnt = 0;
    int n_by_req [8];
    int n_empty    = 0;
    int n_settings = 0;
    logic [NIDX_W+DIDX_W-1:0] written [$];   // addresses hit by scattered weight writes

    always #1 i_clk = ~i_clk;

    lvq_prototype_search_update dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (in_valid),
        .o_ready           (in_ready),
        .i_req_type        (req_type),
        .i_neuron_index    (neuron_index),
        .i_dim_index       (dim_index),
        .i_value           (value),
        .i_range_low       (range_low),
        .i_range_high      (range_high),
        .i_update_sign     (update_sign),
        .o_valid           (out_valid),
        .i_ready           (out_ready),
        .o_winner_index    (winner_index),
        .o_winner_distance (winner_distance),
        .o_read_value      (read_value),
        .o_empty_range     (empty_range),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    lvq_bmu_checker u_bmu_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (in_valid),
        .i_in_ready        (in_ready),
        .i_req_type        (req_type),
        .i_neuron_index    (neuron_index),
        .i_dim_index       (dim_index),
        .i_value           (value),
        .i_range_low       (range_low),
        .i_range_high      (range_high),
        .i_update_sign     (update_sign),
        .i_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .i_winner_index    (winner_index),
        .i_winner_distance (winner_distance),
        .i_read_value      (read_value),
        .i_empty_range     (empty_range),
        .i_psel            (psel),
        .i_penable         (penable),
        .i_pwrite          (pwrite),
        .i_paddr           (paddr),
        .i_pwdata          (pwdata),
        .i_pready          (pready),
        .o_pending         (pending),
        .o_fail_count      (fail_count)
    );

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb: timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending);
            $display("tb: failure");
            $finish;
        end
    end

    // result side: random stall bursts, plus one long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                long_hold = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                out_ready <= 1'b1;
            end else if (rx_idle && $urandom_range(0, 4) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge i_clk);
                out_ready <= 1'b1;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    function automatic t_item mk(input logic [REQ_W-1:0] req, input int nidx, input int didx,
                                 input int val, input int lo, input int hi, input bit sgn);
        t_item it;
        it.req  = req;
        it.nidx = nidx[NIDX_W-1:0];
        it.didx = didx[DIDX_W-1:0];
        it.val  = val[VAL_W-1:0];
        it.lo   = lo[RANGE_W-1:0];
        it.hi   = hi[RANGE_W-1:0];
        it.sgn  = sgn;
        return it;
    endfunction

    function automatic logic [NIDX_W-1:0] ready_neuron();
        if ($urandom_range(0, 5) == 0)
            return TOP_NEURON[NIDX_W-1:0];
        return NIDX_W'($urandom_range(0, N_PRELOAD - 1));
    endfunction

    task automatic send_item(input t_item it);
        int gap;
        int hi_clip;
        gap = (tx_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid     <= 1'b1;
        req_type     <= it.req;
        neuron_index <= it.nidx;
        dim_index    <= it.didx;
        value        <= it.val;
        range_low    <= it.lo;
        range_high   <= it.hi;
        update_sign  <= it.sgn;
        do @(posedge i_clk); while (!in_ready);
        n_by_req[it.req]++;
        hi_clip = (it.hi > NUM_NEURONS_DEF) ? NUM_NEURONS_DEF : 32'(it.hi);
        if (it.req == REQ_SEARCH && it.lo >= hi_clip)
            n_empty++;
    endtask

    // drop valid and wait for the block to drain before touching registers
    task automatic settle();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [CFG_DW-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic gen_random_item(output t_item it);
        int k;
        it.req  = REQ_W'($urandom_range(0, 7));
        it.nidx = NIDX_W'($urandom_range(0, NUM_NEURONS_DEF - 1));
        it.didx = DIDX_W'($urandom_range(0, MAX_DIMS_DEF - 1));
        it.val  = VAL_W'($urandom_range(0, 65535));
        it.lo   = RANGE_W'($urandom_range(0, 2047));
        it.hi   = RANGE_W'($urandom_range(0, 2047));
        it.sgn  = 1'($urandom_range(0, 1));
        // coarse values make equal distances likely at short vectors
        case ($urandom_range(0, 8))
            0: it.val = '0;
            1: it.val = VAL_MID;
            2: it.val = VAL_MAX;
            default: ;
        endcase
        k = $urandom_range(0, 99);
        if (k < 25) begin
            it.req = REQ_WR_WEIGHT;
            if ($urandom_range(0, 2) == 0)
                written.push_back({it.nidx, it.didx});
            else
                it.nidx = ready_neuron();
        end else if (k < 40) begin
            it.req = REQ_WR_SAMPLE;
        end else if (k < 65) begin
            it.req = REQ_SEARCH;
            if ($urandom_range(0, 4) == 0) begin
                // anything at or above the clipped end holds no neuron
                if (it.lo < NUM_NEURONS_DEF)
                    it.hi = RANGE_W'($urandom_range(0, it.lo));
            end else if ($urandom_range(0, 5) == 0) begin
                it.lo = RANGE_W'(TOP_NEURON);
                it.hi = RANGE_W'($urandom_range(NUM_NEURONS_DEF, 2047));
            end else begin
                it.lo = RANGE_W'($urandom_range(0, N_PRELOAD - 1));
                it.hi = RANGE_W'($urandom_range(it.lo + 1, N_PRELOAD));
            end
        end else if (k < 80) begin
            it.req  = REQ_UPDATE;
            it.nidx = ready_neuron();
        end else if (k < 92) begin
            it.req = REQ_RD_WEIGHT;
            if (written.size() > 0 && $urandom_range(0, 2) == 0)
                {it.nidx, it.didx} = written[$urandom_range(0, written.size() - 1)];
            else
                it.nidx = ready_neuron();
        end else begin
            it.req = REQ_W'($urandom_range(REQ_UNKNOWN_FIRST, REQ_UNKNOWN_LAST));
        end
    endtask

    initial begin
        logic [VAL_W-1:0]  tie_vec [MAX_DIMS_DEF];
        logic [LR_W-1:0]   lr_set   [N_PHASES];
        logic [DIMS_W-1:0] dims_set [N_PHASES];
        t_item             it;
        int                n;
        int                d;
        int                p;
        int                i;

        lr_set   = '{16'hFFFF, 16'd0, 16'h8000, 16'd1, 16'd0, 16'hFFFF, 16'd0, 16'd12345};
        dims_set = '{7'd2, 7'd127, 7'd1, 7'd0, 7'd64, 7'd33, 7'd3, 7'd64};
        lr_set[4]   = LR_W'($urandom_range(0, 65535));
        lr_set[6]   = LR_W'($urandom_range(0, 65535));
        dims_set[6] = DIMS_W'($urandom_range(2, 64));

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        cfg_write(REG_DIMS, 32'd64);
        cfg_write(REG_LR, 32'hFFFF);
        n_settings++;

        // fill everything a search, read or update may touch:
        // sample all zero, neuron 0 zero, neurons 1 and 2 equal, top neuron full scale
        for (d = 0; d < MAX_DIMS_DEF; d++)
            tie_vec[d] = VAL_W'($urandom_range(0, 65535));
        for (d = 0; d < MAX_DIMS_DEF; d++)
            send_item(mk(REQ_WR_SAMPLE, $urandom_range(0, 1023), d, 0, 0, 0, 1'b0));
        for (n = 0; n < N_PRELOAD; n++)
            for (d = 0; d < MAX_DIMS_DEF; d++)
                send_item(mk(REQ_WR_WEIGHT, n, d,
                             (n == 0) ? 0 : (n <= 2) ? int'(tie_vec[d]) : $urandom_range(0, 65535),
                             $urandom_range(0, 2047), $urandom_range(0, 2047), 1'b0));
        for (d = 0; d < MAX_DIMS_DEF; d++)
            send_item(mk(REQ_WR_WEIGHT, TOP_NEURON, d, VAL_MAX, 0, 0, 1'b0));

        // directed: extreme distance, clipping, ties, empty ranges, saturation
        send_item(mk(REQ_SEARCH, 0, 0, 0, TOP_NEURON, 1024, 1'b0));
        send_item(mk(REQ_SEARCH, 0, 0, 0, TOP_NEURON, 2047, 1'b0));
        send_item(mk(REQ_SEARCH, 0, 0, 0, 0, N_PRELOAD, 1'b0));
        send_item(mk(REQ_SEARCH, 0, 0, 0, 1, 3, 1'b0));
        send_item(mk(REQ_SEARCH, 0, 0, 0, 5, 5, 1'b0));
        send_item(mk(REQ_SEARCH, 0, 0, 0, 2047, 0, 1'b0));
        send_item(mk(REQ_SEARCH, 0, 0, 0, 1024, 2047, 1'b0));
        send_item(mk(REQ_SEARCH, 0, 0, 0, 7, 3, 1'b0));
        send_item(mk(REQ_RD_WEIGHT, TOP_NEURON, 63, 0, 0, 0, 1'b0));
        send_item(mk(REQ_RD_WEIGHT, 0, 0, 0, 0, 0, 1'b0));
        send_item(mk(REQ_UPDATE, TOP_NEURON, 0, 0, 0, 0, 1'b0));
        send_item(mk(REQ_RD_WEIGHT, TOP_NEURON, 0, 0, 0, 0, 1'b0));
        send_item(mk(REQ_WR_SAMPLE, 0, 0, VAL_MAX, 0, 0, 1'b0));
        send_item(mk(REQ_UPDATE, 0, 0, 0, 0, 0, 1'b1));          // repel clamps at zero
        send_item(mk(REQ_WR_WEIGHT, 0, 1, VAL_MAX, 0, 0, 1'b0));
        send_item(mk(REQ_UPDATE, 0, 0, 0, 0, 0, 1'b1));          // repel clamps at full scale
        send_item(mk(REQ_RD_WEIGHT, 0, 1, 0, 0, 0, 1'b0));
        send_item(mk(REQ_RD_WEIGHT, 0, 0, 0, 0, 0, 1'b0));
        send_item(mk(REQ_UNKNOWN_FIRST, 1023, 63, VAL_MAX, 2047, 2047, 1'b1));
        send_item(mk(REQ_UNKNOWN_FIRST + 3'd1, 1023, 63, VAL_MAX, 2047, 2047, 1'b1));
        send_item(mk(REQ_UNKNOWN_LAST, 1023, 63, VAL_MAX, 2047, 2047, 1'b1));
        send_item(mk(REQ_WR_WEIGHT, TOP_NEURON, 63, VAL_MAX, 0, 0, 1'b0));
        send_item(mk(REQ_WR_SAMPLE, 0, 63, VAL_MAX, 0, 0, 1'b0));
        send_item(mk(REQ_SEARCH, 0, 0, 0, 0, N_PRELOAD, 1'b0));
        settle();

        for (p = 0; p < N_PHASES; p++) begin
            cfg_write(REG_LR, {16'd0, lr_set[p]});
            cfg_write(REG_DIMS, {25'd0, dims_set[p]});
            n_settings++;
            if (p == N_PHASES - 1) begin
                tx_idle = 1'b0;
                rx_idle = 1'b0;
            end
            if (p == 3)
                long_hold = 1'b1;
            for (i = 0; i < PHASE_ITEMS; i++) begin
                gen_random_item(it);
                send_item(it);
            end
            settle();
        end

        repeat (20) @(negedge i_clk);
        $display("tb: %0d weight writes, %0d sample writes, %0d reads, %0d updates, %0d unknown",
                 n_by_req[REQ_WR_WEIGHT], n_by_req[REQ_WR_SAMPLE], n_by_req[REQ_RD_WEIGHT],
                 n_by_req[REQ_UPDATE], n_by_req[5] + n_by_req[6] + n_by_req[7]);
        $display("tb: %0d searches (%0d over empty ranges) across %0d register settings",
                 n_by_req[REQ_SEARCH], n_empty, n_settings);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
`default_nettype wire
